FILE: src/mrf_pkg.sv
// ============================================================================
// Modbus RTU request framer package
// Shared types, function codes, error codes and the CRC-16/MODBUS byte update.
// ============================================================================
package mrf_pkg;

  // Modbus function codes handled by the framer
  localparam logic [7:0] FN_READ_COILS     = 8'h01;
  localparam logic [7:0] FN_READ_HOLDING   = 8'h03;
  localparam logic [7:0] FN_WRITE_COILS    = 8'h0F;
  localparam logic [7:0] FN_WRITE_REGS     = 8'h10;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Largest quantities whose byte count still fits in one byte
  localparam logic [15:0] MAX_COIL_QTY = 16'd2040;
  localparam logic [15:0] MAX_REG_QTY  = 16'd127;

  typedef enum logic {
    CMD_HEADER = 1'b0,
    CMD_DATA   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_FUNCTION   = 2'd1,
    ERR_BYTE_COUNT = 2'd2,
    ERR_NO_DATA    = 2'd3
  } err_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  slave_id;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] quantity;
    logic [15:0] data_word;
  } item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       byte_valid;
    logic       last;
    err_e       error_code;
  } result_t;

  // One byte through the reflected CRC-16/MODBUS, bit by bit.
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: src/modbus_rtu_request_framer.sv
// ============================================================================
// Modbus RTU request framer
// Turns header and data items into Modbus RTU request bytes with CRC-16/MODBUS.
// ============================================================================
// Each accepted item produces between one and nine output transfers, one byte
// per cycle unless the output stalls: a read header gives eight, a write header
// seven (nine when the byte count is zero), a data item one or two payload bytes
// plus two CRC bytes after the last one, and every error a single transfer. The
// single output byte port sets this figure. Input items are buffered one deep,
// and the next item is taken in the same cycle that the previous one hands off
// its final byte, so a stream of items flows with no idle cycles between them.
module modbus_rtu_request_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // slave_id[7:0], function_code[15:8], start_address[31:16], quantity[47:32],
  // data_word[63:48]
  input  logic [63:0] s_axis_tdata_i,
  // cmd[0]
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // frame_byte[7:0]
  output logic [7:0]  m_axis_tdata_o,
  // byte_valid[0], error_code[2:1]
  output logic [2:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);
  import mrf_pkg::*;

  item_t   in_item, buf_item;
  logic    buf_valid, pop;
  logic    core_valid, out_ready;
  result_t core_res, out_res;

  always_comb begin
    in_item.cmd           = cmd_e'(s_axis_tuser_i);
    in_item.slave_id      = s_axis_tdata_i[7:0];
    in_item.function_code = s_axis_tdata_i[15:8];
    in_item.start_address = s_axis_tdata_i[31:16];
    in_item.quantity      = s_axis_tdata_i[47:32];
    in_item.data_word     = s_axis_tdata_i[63:48];
  end

  mrf_item_buf u_item_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (in_item),
    .valid_o (buf_valid),
    .item_o  (buf_item),
    .pop_i   (pop)
  );

  mrf_framer_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (buf_valid),
    .item_i       (buf_item),
    .pop_o        (pop),
    .res_valid_o  (core_valid),
    .res_o        (core_res),
    .res_ready_i  (out_ready)
  );

  mrf_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (core_valid),
    .ready_o (out_ready),
    .res_i   (core_res),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (out_res)
  );

  assign m_axis_tdata_o = out_res.frame_byte;
  assign m_axis_tuser_o = {out_res.error_code, out_res.byte_valid};
  assign m_axis_tlast_o = out_res.last;

endmodule

FILE: src/mrf_item_buf.sv
// ============================================================================
// Modbus RTU request framer input buffer
// Holds one accepted item while the framer core emits its bytes.
// ============================================================================
module mrf_item_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  mrf_pkg::item_t item_i,
  output logic          valid_o,
  output mrf_pkg::item_t item_o,
  input  logic          pop_i
);
  import mrf_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  // A new item may enter in the cycle the held one hands off its final byte.
  assign ready_o = !valid_q || pop_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: src/mrf_framer_core.sv
// ============================================================================
// Modbus RTU request framer core
// Decodes the held item and emits its result bytes one per cycle unless stalled,
// keeping the running CRC and the payload bookkeeping between items.
// ============================================================================
module mrf_framer_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  mrf_pkg::item_t  item_i,
  output logic            pop_o,
  output logic            res_valid_o,
  output mrf_pkg::result_t res_o,
  input  logic            res_ready_i
);
  import mrf_pkg::*;

  logic [3:0]  idx_q, idx_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  data_left_q, data_left_d;
  logic        reg_mode_q, reg_mode_d;
  logic        awaiting_q, awaiting_d;

  logic        is_hdr, is_rd, is_wr_coil, is_wr_reg, fn_ok, cnt_ovf;
  logic [16:0] coil_sum;
  logic [7:0]  byte_cnt;
  logic [1:0]  pay_n;
  logic [7:0]  left_after;
  logic        has_tail;
  err_e        err;
  logic [3:0]  n_res;
  logic        item_end, fire, feed;
  logic [7:0]  data_byte;
  logic [15:0] crc_base;
  result_t     res;

  always_comb begin
    is_hdr     = (item_i.cmd == CMD_HEADER);
    is_rd      = (item_i.function_code == FN_READ_COILS) ||
                 (item_i.function_code == FN_READ_HOLDING);
    is_wr_coil = (item_i.function_code == FN_WRITE_COILS);
    is_wr_reg  = (item_i.function_code == FN_WRITE_REGS);
    fn_ok      = is_rd || is_wr_coil || is_wr_reg;
    cnt_ovf    = (is_wr_coil && (item_i.quantity > MAX_COIL_QTY)) ||
                 (is_wr_reg && (item_i.quantity > MAX_REG_QTY));
    coil_sum   = {1'b0, item_i.quantity} + 17'd7;
    if (is_wr_coil) begin
      byte_cnt = coil_sum[10:3];
    end else if (is_wr_reg) begin
      byte_cnt = {item_i.quantity[6:0], 1'b0};
    end else begin
      byte_cnt = 8'd0;
    end

    pay_n      = reg_mode_q ? 2'd2 : 2'd1;
    left_after = (data_left_q >= {6'd0, pay_n}) ? data_left_q - {6'd0, pay_n} : 8'd0;

    // Error kind and result count of the held item
    err      = ERR_NONE;
    has_tail = 1'b0;
    n_res    = 4'd1;
    if (is_hdr) begin
      if (!fn_ok) begin
        err = ERR_FUNCTION;
      end else if (cnt_ovf) begin
        err = ERR_BYTE_COUNT;
      end else if (is_rd) begin
        has_tail = 1'b1;
        n_res    = 4'd8;
      end else begin
        has_tail = (byte_cnt == 8'd0);
        n_res    = has_tail ? 4'd9 : 4'd7;
      end
    end else begin
      if (!awaiting_q) begin
        err = ERR_NO_DATA;
      end else begin
        has_tail = (left_after == 8'd0);
        n_res    = {2'b00, pay_n} + (has_tail ? 4'd2 : 4'd0);
      end
    end

    // Payload byte at the current position
    if (is_hdr) begin
      unique case (idx_q)
        4'd0:    data_byte = item_i.slave_id;
        4'd1:    data_byte = item_i.function_code;
        4'd2:    data_byte = item_i.start_address[15:8];
        4'd3:    data_byte = item_i.start_address[7:0];
        4'd4:    data_byte = item_i.quantity[15:8];
        4'd5:    data_byte = item_i.quantity[7:0];
        default: data_byte = byte_cnt;
      endcase
    end else begin
      data_byte = (reg_mode_q && (idx_q == 4'd0)) ? item_i.data_word[15:8]
                                                   : item_i.data_word[7:0];
    end

    item_end = (idx_q == n_res - 4'd1);
    feed     = 1'b0;
    res      = '{frame_byte: 8'h00, byte_valid: 1'b0, last: 1'b1, error_code: err};
    if (err == ERR_NONE) begin
      res.byte_valid = 1'b1;
      res.last       = 1'b0;
      if (has_tail && (idx_q == n_res - 4'd2)) begin
        res.frame_byte = crc_q[7:0];
      end else if (has_tail && item_end) begin
        res.frame_byte = crc_q[15:8];
        res.last       = 1'b1;
      end else begin
        res.frame_byte = data_byte;
        feed           = 1'b1;
      end
    end

    // A header restarts the CRC at its first byte.
    crc_base = (is_hdr && (idx_q == 4'd0)) ? CRC_INIT : crc_q;
    fire     = item_valid_i && res_ready_i;

    idx_d       = idx_q;
    crc_d       = crc_q;
    data_left_d = data_left_q;
    reg_mode_d  = reg_mode_q;
    awaiting_d  = awaiting_q;
    if (fire) begin
      idx_d = item_end ? 4'd0 : idx_q + 4'd1;
      if (feed) begin
        crc_d = crc16_feed(crc_base, data_byte);
      end
      if (item_end) begin
        if (is_hdr) begin
          awaiting_d  = 1'b0;
          data_left_d = 8'd0;
          if ((err == ERR_NONE) && !is_rd) begin
            reg_mode_d  = is_wr_reg;
            data_left_d = byte_cnt;
            awaiting_d  = (byte_cnt != 8'd0);
          end
        end else if (awaiting_q) begin
          data_left_d = left_after;
          awaiting_d  = !has_tail;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 4'd0;
      crc_q       <= CRC_INIT;
      data_left_q <= 8'd0;
      reg_mode_q  <= 1'b0;
      awaiting_q  <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      crc_q       <= crc_d;
      data_left_q <= data_left_d;
      reg_mode_q  <= reg_mode_d;
      awaiting_q  <= awaiting_d;
    end
  end

  assign pop_o       = fire && item_end;
  assign res_valid_o = item_valid_i;
  assign res_o       = res;

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= 4'd8)
    else $error("byte position beyond the longest frame");
  a_pop_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (idx_q == 4'd0))
    else $error("byte position not restarted after an item ended");
  a_await_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    awaiting_q |-> (data_left_q != 8'd0))
    else $error("payload expected with no bytes left");
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.byte_valid) |-> (res_o.last && pop_o == res_ready_i))
    else $error("error result must be a single closing transfer");
`endif

endmodule

FILE: src/mrf_out_reg.sv
// ============================================================================
// Modbus RTU request framer output register
// Holds one result until the downstream side takes it.
// ============================================================================
module mrf_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  mrf_pkg::result_t res_i,
  output logic             valid_o,
  input  logic             ready_i,
  output mrf_pkg::result_t res_o
);
  import mrf_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;
  logic    load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Modbus RTU request framer testbench
// Streams header and data items into the framer and checks every output byte
// against a cycle-free predictor that builds the same frames and CRCs.
// ============================================================================
module tb;
  import mrf_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i  = '0;
  logic        s_axis_tuser_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  modbus_rtu_request_framer i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  item_t   pending_items[$];
  result_t frame_bytes_due[$];

  int items_queued  = 0;
  int items_sent    = 0;
  int bytes_seen    = 0;
  int frames_seen   = 0;
  int errors_seen   = 0;
  int mismatches    = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;

  // Framer state as the predictor sees it.
  logic [15:0] fr_crc       = CRC_INIT;
  logic [7:0]  fr_left      = 8'd0;
  logic        fr_regs      = 1'b0;
  logic        fr_want_data = 1'b0;

  function automatic void push_byte(logic [7:0] b, logic is_last, err_e err);
    result_t r;
    r.frame_byte = b;
    r.byte_valid = (err == ERR_NONE);
    r.last       = is_last;
    r.error_code = err;
    frame_bytes_due.push_back(r);
  endfunction

  function automatic void send_byte(logic [7:0] b);
    fr_crc = fr_crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      fr_crc = fr_crc[0] ? ((fr_crc >> 1) ^ CRC_POLY) : (fr_crc >> 1);
    end
    push_byte(b, 1'b0, ERR_NONE);
  endfunction

  function automatic void close_frame();
    push_byte(fr_crc[7:0], 1'b0, ERR_NONE);
    push_byte(fr_crc[15:8], 1'b1, ERR_NONE);
    fr_want_data = 1'b0;
    fr_left      = 8'd0;
  endfunction

  function automatic void predict_frame_bytes(item_t it);
    int unsigned count;
    logic [7:0]  fn;
    count = 0;
    fn    = it.function_code;
    if (it.cmd == CMD_HEADER) begin
      // A new header always drops whatever payload was still pending.
      fr_want_data = 1'b0;
      fr_left      = 8'd0;
      if (fn != FN_READ_COILS && fn != FN_READ_HOLDING &&
          fn != FN_WRITE_COILS && fn != FN_WRITE_REGS) begin
        push_byte(8'h00, 1'b1, ERR_FUNCTION);
        return;
      end
      if (fn == FN_WRITE_COILS) begin
        count = (int'(it.quantity) + 7) / 8;
      end else if (fn == FN_WRITE_REGS) begin
        count = int'(it.quantity) * 2;
      end
      if (count > 255) begin
        push_byte(8'h00, 1'b1, ERR_BYTE_COUNT);
        return;
      end
      fr_crc = CRC_INIT;
      send_byte(it.slave_id);
      send_byte(fn);
      send_byte(it.start_address[15:8]);
      send_byte(it.start_address[7:0]);
      send_byte(it.quantity[15:8]);
      send_byte(it.quantity[7:0]);
      if (fn == FN_READ_COILS || fn == FN_READ_HOLDING) begin
        close_frame();
        return;
      end
      send_byte(count[7:0]);
      fr_regs = (fn == FN_WRITE_REGS);
      fr_left = count[7:0];
      if (count == 0) begin
        close_frame();
      end else begin
        fr_want_data = 1'b1;
      end
    end else if (!fr_want_data) begin
      push_byte(8'h00, 1'b1, ERR_NO_DATA);
    end else begin
      if (fr_regs) begin
        send_byte(it.data_word[15:8]);
        send_byte(it.data_word[7:0]);
        fr_left = (fr_left >= 8'd2) ? fr_left - 8'd2 : 8'd0;
      end else begin
        send_byte(it.data_word[7:0]);
        fr_left = (fr_left >= 8'd1) ? fr_left - 8'd1 : 8'd0;
      end
      if (fr_left == 8'd0) begin
        close_frame();
      end
    end
  endfunction

  // Sender: holds an item until it is taken, then offers the next one unless
  // it decides to idle this cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_frame_bytes(pending_items.pop_front());
        items_sent++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_items.size() > 0 &&
            !((items_sent < 160 || items_sent >= 230) && $urandom_range(0, 99) < 15)) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {pending_items[0].data_word, pending_items[0].quantity,
                              pending_items[0].start_address,
                              pending_items[0].function_code, pending_items[0].slave_id};
          s_axis_tuser_i  <= pending_items[0].cmd;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each transfer against the oldest expected byte.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        bytes_seen++;
        if (m_axis_tlast_o && m_axis_tuser_o[0]) frames_seen++;
        if (!m_axis_tuser_o[0]) errors_seen++;
        if (frame_bytes_due.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual tdata %h tuser %h tlast %b",
                   $realtime, m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
          mismatches++;
        end else begin
          want = frame_bytes_due.pop_front();
          if (m_axis_tdata_o !== want.frame_byte) begin
            $display("%0t: frame_byte mismatch, expected %h, actual %h",
                     $realtime, want.frame_byte, m_axis_tdata_o);
            mismatches++;
          end
          if (m_axis_tuser_o[0] !== want.byte_valid) begin
            $display("%0t: byte_valid mismatch, expected %b, actual %b",
                     $realtime, want.byte_valid, m_axis_tuser_o[0]);
            mismatches++;
          end
          if (m_axis_tlast_o !== want.last) begin
            $display("%0t: last mismatch, expected %b, actual %b",
                     $realtime, want.last, m_axis_tlast_o);
            mismatches++;
          end
          if (m_axis_tuser_o[2:1] !== want.error_code) begin
            $display("%0t: error_code mismatch, expected %0d, actual %0d",
                     $realtime, want.error_code, m_axis_tuser_o[2:1]);
            mismatches++;
          end
        end
      end
      // One long back-pressure window lets the item buffer fill and stall.
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (!hold_done && bytes_seen >= 100) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= !((bytes_seen < 500 || bytes_seen >= 750) &&
                             $urandom_range(0, 99) < 15);
      end
    end
  end

  task automatic queue_header(logic [7:0] id, logic [7:0] fn, logic [15:0] addr,
                              logic [15:0] qty);
    item_t it;
    it.cmd           = CMD_HEADER;
    it.slave_id      = id;
    it.function_code = fn;
    it.start_address = addr;
    it.quantity      = qty;
    it.data_word     = 16'($urandom);
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic queue_data(logic [15:0] word);
    item_t it;
    it.cmd           = CMD_DATA;
    it.slave_id      = 8'($urandom);
    it.function_code = 8'($urandom);
    it.start_address = 16'($urandom);
    it.quantity      = 16'($urandom);
    it.data_word     = word;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // A write header followed by n_data payload items; n_data may fall short.
  task automatic queue_write(logic [7:0] fn, logic [15:0] qty, int n_data);
    queue_header(8'($urandom), fn, 16'($urandom), qty);
    for (int i = 0; i < n_data; i++) begin
      queue_data(16'($urandom));
    end
  endtask

  initial begin
    int pick;
    int qty;
    int need;
    bit big_regs_done;
    bit big_coils_done;
    logic [7:0] fn;

    big_regs_done  = 1'b0;
    big_coils_done = 1'b0;

    // Directed part.
    queue_data(16'hFFFF);
    queue_header(8'h00, FN_READ_COILS, 16'h0000, 16'h0000);
    queue_header(8'hFF, FN_READ_HOLDING, 16'hFFFF, 16'hFFFF);
    queue_header(8'h5A, 8'h00, 16'h1234, 16'h0001);
    queue_header(8'hA5, 8'hFF, 16'hABCD, 16'h0002);
    queue_header(8'h11, 8'h02, 16'h0000, 16'h0003);
    queue_header(8'h22, FN_WRITE_COILS, 16'h0010, MAX_COIL_QTY + 16'd1);
    queue_header(8'h33, FN_WRITE_REGS, 16'h0020, MAX_REG_QTY + 16'd1);
    queue_header(8'h44, FN_WRITE_COILS, 16'h0030, 16'hFFFF);
    queue_header(8'h55, FN_WRITE_REGS, 16'h0040, 16'h0000);
    queue_header(8'h66, FN_WRITE_COILS, 16'h0050, 16'h0000);
    queue_header(8'h77, FN_WRITE_COILS, 16'h0060, 16'd9);
    queue_data(16'h12AB);
    queue_data(16'hFF55);
    queue_header(8'h88, FN_WRITE_REGS, 16'h0070, 16'd2);
    queue_data(16'hFFFF);
    queue_data(16'h0000);
    queue_data(16'h0F0F);
    queue_header(8'h99, FN_WRITE_REGS, 16'h0080, 16'd3);
    queue_data(16'h1234);
    queue_header(8'hAA, FN_READ_COILS, 16'h0090, 16'd10);
    queue_header(8'hBB, FN_WRITE_COILS, 16'h00A0, 16'd8);
    queue_header(8'hCC, 8'h7F, 16'h00B0, 16'd1);
    queue_data(16'h8001);

    // Random part: mostly complete write frames, the rest noise.
    while (items_queued < 330) begin
      if (!big_regs_done && items_queued >= 100) begin
        big_regs_done = 1'b1;
        queue_write(FN_WRITE_REGS, MAX_REG_QTY, int'(MAX_REG_QTY));
      end else if (!big_coils_done && items_queued >= 250) begin
        // Largest coil byte count, cut short by the next header.
        big_coils_done = 1'b1;
        queue_write(FN_WRITE_COILS, MAX_COIL_QTY, 12);
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        qty = $urandom_range(0, 8);
        queue_write(FN_WRITE_REGS, 16'(qty), qty);
      end else if (pick < 65) begin
        qty = $urandom_range(0, 60);
        queue_write(FN_WRITE_COILS, 16'(qty), (qty + 7) / 8);
      end else if (pick < 77) begin
        fn = ($urandom_range(0, 1) == 0) ? FN_READ_COILS : FN_READ_HOLDING;
        queue_header(8'($urandom), fn, 16'($urandom), 16'($urandom));
      end else if (pick < 84) begin
        fn   = ($urandom_range(0, 1) == 0) ? FN_WRITE_COILS : FN_WRITE_REGS;
        qty  = $urandom_range(2, 40);
        need = (fn == FN_WRITE_REGS) ? qty : (qty + 7) / 8;
        queue_write(fn, 16'(qty), $urandom_range(0, need - 1));
      end else if (pick < 90) begin
        queue_data(16'($urandom));
      end else if (pick < 95) begin
        do begin
          fn = 8'($urandom);
        end while (fn == FN_READ_COILS || fn == FN_READ_HOLDING ||
                   fn == FN_WRITE_COILS || fn == FN_WRITE_REGS);
        queue_header(8'($urandom), fn, 16'($urandom), 16'($urandom));
      end else if ($urandom_range(0, 1) == 0) begin
        queue_header(8'($urandom), FN_WRITE_COILS, 16'($urandom),
                     16'($urandom_range(int'(MAX_COIL_QTY) + 1, 65535)));
      end else begin
        queue_header(8'($urandom), FN_WRITE_REGS, 16'($urandom),
                     16'($urandom_range(int'(MAX_REG_QTY) + 1, 65535)));
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || s_axis_tvalid_i || frame_bytes_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);

    $display("Sent %0d items; checked %0d output bytes in %0d frames plus %0d error transfers.",
             items_sent, bytes_seen, frames_seen, errors_seen);
    if (mismatches == 0) begin
      $display("** modbus_rtu_request_framer: PASSED **");
    end else begin
      $display("** modbus_rtu_request_framer: FAILED **");
    end
    $finish;
  end

  // Ends the run when work is outstanding but nothing moves for too long.
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (pending_items.size() == 0 && frame_bytes_due.size() == 0)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
    $display("** modbus_rtu_request_framer: FAILED **");
    $finish;
  end

endmodule
